// File: hdl/stc_pkg.sv
// Shared types, codes and constants of the scrolling text console.
`timescale 1ns / 1ps
package stc_pkg;

    localparam int MAX_COLS_DEF = 32;
    localparam int MAX_ROWS_DEF = 16;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 5;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 40;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 8;

    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] CR_CODE    = 8'd13;
    localparam logic [7:0] LF_CODE    = 8'd10;
    localparam logic [7:0] CASE_GAP   = 8'd32;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [CFG_IW-1:0] REG_COLS = 2'd0;
    localparam logic [CFG_IW-1:0] REG_ROWS = 2'd1;
    localparam logic [CFG_IW-1:0] REG_WRAP = 2'd2;
    localparam logic [CFG_IW-1:0] REG_FONT = 2'd3;

    localparam logic [COL_W-1:0] COLS_RESET = 6'd32;
    localparam logic [ROW_W-1:0] ROWS_RESET = 5'd16;
    localparam logic [7:0]       FONT_RESET = 8'd127;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_COPY_PRE,
        S_CHAR,
        S_COPY_WRAP,
        S_WRITE,
        S_FILL,
        S_READ_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic move;
        logic clear;
        logic sat_row;
        logic copy_start;
        logic copy_step;
        logic copy_finish;
        logic do_cr;
        logic do_lf;
        logic do_wrap;
        logic write_cell;
        logic fill_start;
        logic fill_step;
        logic read_capture;
        logic result_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       need_scroll;
        logic       is_cr;
        logic       is_lf;
        logic       line_end;
        logic       wrap_en;
        logic       wrap_scroll;
        logic       row_valid;
        logic       copy_idle;
        logic       fill_last;
        logic       out_free;
    } t_dp_stat;

endpackage

// File: hdl/stc_ram.sv
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/stc_ctrl.sv
// Controller state machine of the scrolling text console.
`timescale 1ns / 1ps
module stc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  stc_pkg::t_dp_stat i_stat,
    output stc_pkg::t_dp_cmd  o_cmd
);
    stc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = stc_pkg::S_DISPATCH;
            end
            stc_pkg::S_DISPATCH: begin
                unique case (i_stat.command)
                    stc_pkg::CMD_PUT:
                        n_state = i_stat.need_scroll ? stc_pkg::S_COPY_PRE : stc_pkg::S_CHAR;
                    stc_pkg::CMD_READ: n_state = stc_pkg::S_READ_WAIT;
                    default: n_state = stc_pkg::S_DONE;
                endcase
            end
            stc_pkg::S_COPY_PRE: begin
                if (i_stat.copy_idle) n_state = stc_pkg::S_CHAR;
            end
            stc_pkg::S_CHAR: begin
                if (i_stat.is_cr || i_stat.is_lf) begin
                    n_state = stc_pkg::S_DONE;
                end else if (i_stat.line_end) begin
                    if (!i_stat.wrap_en) begin
                        n_state = stc_pkg::S_DONE;
                    end else if (i_stat.wrap_scroll) begin
                        n_state = stc_pkg::S_COPY_WRAP;
                    end else begin
                        n_state = stc_pkg::S_WRITE;
                    end
                end else begin
                    n_state = stc_pkg::S_WRITE;
                end
            end
            stc_pkg::S_COPY_WRAP: begin
                if (i_stat.copy_idle) n_state = stc_pkg::S_WRITE;
            end
            stc_pkg::S_WRITE: begin
                n_state = i_stat.row_valid ? stc_pkg::S_DONE : stc_pkg::S_FILL;
            end
            stc_pkg::S_FILL: begin
                if (i_stat.fill_last) n_state = stc_pkg::S_DONE;
            end
            stc_pkg::S_READ_WAIT: begin
                n_state = stc_pkg::S_DONE;
            end
            stc_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = stc_pkg::S_IDLE;
            end
            default: n_state = stc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            stc_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            stc_pkg::S_DISPATCH: begin
                unique case (i_stat.command)
                    stc_pkg::CMD_PUT: begin
                        o_cmd.sat_row    = 1'b1;
                        o_cmd.copy_start = i_stat.need_scroll;
                    end
                    stc_pkg::CMD_MOVE:  o_cmd.move  = 1'b1;
                    stc_pkg::CMD_CLEAR: o_cmd.clear = 1'b1;
                    default: ;
                endcase
            end
            stc_pkg::S_COPY_PRE, stc_pkg::S_COPY_WRAP: begin
                o_cmd.copy_step   = !i_stat.copy_idle;
                o_cmd.copy_finish = i_stat.copy_idle;
            end
            stc_pkg::S_CHAR: begin
                if (i_stat.is_cr) begin
                    o_cmd.do_cr = 1'b1;
                end else if (i_stat.is_lf) begin
                    o_cmd.do_lf = 1'b1;
                end else if (i_stat.line_end && i_stat.wrap_en) begin
                    o_cmd.do_wrap    = 1'b1;
                    o_cmd.copy_start = i_stat.wrap_scroll;
                end
            end
            stc_pkg::S_WRITE: begin
                o_cmd.write_cell = i_stat.row_valid;
                o_cmd.fill_start = !i_stat.row_valid;
            end
            stc_pkg::S_FILL: begin
                o_cmd.fill_step = 1'b1;
            end
            stc_pkg::S_READ_WAIT: begin
                o_cmd.read_capture = 1'b1;
            end
            stc_pkg::S_DONE: begin
                o_cmd.result_load = i_stat.out_free;
            end
            default: ;
        endcase
    end
endmodule

// File: hdl/stc_datapath.sv
// Datapath of the scrolling text console: registers, cursor, row flags and screen store.
`timescale 1ns / 1ps
module stc_datapath #(
    parameter int MAX_COLS = stc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = stc_pkg::MAX_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [stc_pkg::IN_W-1:0]   i_in_data,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [stc_pkg::OUT_W-1:0]  o_out_data,
    input  logic                       i_cfg_valid,
    input  logic [stc_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [stc_pkg::CFG_DW-1:0] i_cfg_data,
    input  stc_pkg::t_dp_cmd           i_cmd,
    output stc_pkg::t_dp_stat          o_stat
);
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW = RW + CW;
    localparam logic [CW-1:0] LAST_COL = CW'(MAX_COLS - 1);

    // Configuration.
    logic [stc_pkg::COL_W-1:0] r_cols;
    logic [stc_pkg::ROW_W-1:0] r_rows;
    logic                      r_wrap;
    logic [7:0]                r_font;

    // Latched input item.
    logic [1:0] r_command;
    logic [7:0] r_ch;
    logic [4:0] r_tcol;
    logic [3:0] r_trow;

    logic [stc_pkg::COL_W-1:0] r_cur_col;
    logic [stc_pkg::ROW_W-1:0] r_cur_row;
    logic [MAX_ROWS-1:0]       r_row_vld;

    logic [stc_pkg::ROW_W-1:0] r_cnt_row;
    logic [CW-1:0]             r_cnt_col;
    logic                      r_cp_vld;
    logic [AW-1:0]             r_cp_addr;

    logic       r_drawn;
    logic [4:0] r_dcol;
    logic [3:0] r_drow;
    logic [7:0] r_dchar;
    logic [1:0] r_scrolls;
    logic [7:0] r_cell;

    logic                      r_out_valid;
    logic [stc_pkg::OUT_W-1:0] r_out_data;

    logic [stc_pkg::COL_W-1:0] cols;
    logic [stc_pkg::ROW_W-1:0] rows;
    logic [stc_pkg::COL_W-1:0] tcol_c;
    logic [stc_pkg::ROW_W-1:0] trow_c;
    logic [7:0]                ch_f;
    logic                      latch;
    logic                      copy_issue;
    logic                      out_free;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [7:0]                ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [7:0]                ram_rdata;

    always_comb begin
        if (r_cols == '0) begin
            cols = stc_pkg::COL_W'(1);
        end else if ({1'b0, r_cols} > (stc_pkg::COL_W + 1)'(MAX_COLS)) begin
            cols = stc_pkg::COL_W'(MAX_COLS);
        end else begin
            cols = r_cols;
        end
        if (r_rows == '0) begin
            rows = stc_pkg::ROW_W'(1);
        end else if ({1'b0, r_rows} > (stc_pkg::ROW_W + 1)'(MAX_ROWS)) begin
            rows = stc_pkg::ROW_W'(MAX_ROWS);
        end else begin
            rows = r_rows;
        end
    end

    assign tcol_c = ({1'b0, r_tcol} >= cols) ? cols - 1'b1 : {1'b0, r_tcol};
    assign trow_c = ({1'b0, r_trow} >= rows) ? rows - 1'b1 : {1'b0, r_trow};
    assign ch_f   = (r_ch > r_font) ? r_ch - stc_pkg::CASE_GAP : r_ch;

    assign latch      = i_cmd.in_ready && i_in_valid;
    assign copy_issue = i_cmd.copy_step && (r_cnt_row < rows);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_cur_row[RW-1:0], r_cur_col[CW-1:0]};
        ram_wdata = ch_f;
        if (r_cp_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_addr;
            ram_wdata = ram_rdata;
        end else if (i_cmd.fill_step) begin
            ram_we    = 1'b1;
            ram_waddr = {r_cur_row[RW-1:0], r_cnt_col};
            ram_wdata = (stc_pkg::COL_W'(r_cnt_col) == r_cur_col) ? ch_f
                                                                 : stc_pkg::SPACE_CODE;
        end else if (i_cmd.write_cell) begin
            ram_we = 1'b1;
        end
        ram_raddr = i_cmd.copy_step ? {r_cnt_row[RW-1:0], r_cnt_col}
                                    : {trow_c[RW-1:0], tcol_c[CW-1:0]};
    end

    stc_ram #(
        .WIDTH (8),
        .DEPTH (2 ** AW)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= stc_pkg::COLS_RESET;
            r_rows <= stc_pkg::ROWS_RESET;
            r_wrap <= 1'b0;
            r_font <= stc_pkg::FONT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stc_pkg::REG_COLS: r_cols <= i_cfg_data[stc_pkg::COL_W-1:0];
                stc_pkg::REG_ROWS: r_rows <= i_cfg_data[stc_pkg::ROW_W-1:0];
                stc_pkg::REG_WRAP: r_wrap <= i_cfg_data[0];
                stc_pkg::REG_FONT: r_font <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (latch) begin
            r_command <= i_in_data[1:0];
            r_ch      <= i_in_data[9:2];
            r_tcol    <= i_in_data[14:10];
            r_trow    <= i_in_data[18:15];
        end
        if (i_cmd.copy_start || i_cmd.fill_start) begin
            r_cnt_col <= '0;
        end else if (copy_issue || i_cmd.fill_step) begin
            r_cnt_col <= (r_cnt_col == LAST_COL) ? '0 : r_cnt_col + 1'b1;
        end
        if (i_cmd.copy_start) begin
            r_cnt_row <= stc_pkg::ROW_W'(1);
        end else if (copy_issue && r_cnt_col == LAST_COL) begin
            r_cnt_row <= r_cnt_row + 1'b1;
        end
        r_cp_addr <= {RW'(r_cnt_row - 1'b1), r_cnt_col};
        if (i_cmd.read_capture) begin
            r_cell <= r_row_vld[trow_c[RW-1:0]] ? ram_rdata : stc_pkg::SPACE_CODE;
        end else if (latch) begin
            r_cell <= '0;
        end
        if (i_cmd.result_load) begin
            r_out_data <= {1'b0, r_cell, r_cur_row, r_cur_col, r_scrolls,
                           r_dchar, r_drow, r_dcol, r_drawn};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_row_vld   <= '0;
            r_cp_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_drawn     <= 1'b0;
            r_dcol      <= '0;
            r_drow      <= '0;
            r_dchar     <= '0;
            r_scrolls   <= '0;
        end else begin
            r_cp_vld <= copy_issue;
            if (latch) begin
                r_drawn   <= 1'b0;
                r_dcol    <= '0;
                r_drow    <= '0;
                r_dchar   <= '0;
                r_scrolls <= '0;
            end
            if (i_cmd.move) begin
                r_cur_col <= tcol_c;
                r_cur_row <= trow_c;
            end
            if (i_cmd.clear) begin
                r_cur_col <= '0;
                r_cur_row <= '0;
                r_row_vld <= '0;
            end
            if (i_cmd.sat_row && r_cur_row > rows) begin
                r_cur_row <= rows;
            end
            if (copy_issue && r_cnt_col == '0) begin
                r_row_vld[RW'(r_cnt_row - 1'b1)] <= r_row_vld[r_cnt_row[RW-1:0]];
            end
            if (i_cmd.copy_finish) begin
                r_row_vld[RW'(rows - 1'b1)] <= 1'b0;
                r_cur_row <= (r_cur_row != '0) ? r_cur_row - 1'b1 : '0;
                r_scrolls <= r_scrolls + 1'b1;
            end
            if (i_cmd.do_cr) begin
                r_cur_col <= '0;
            end
            if (i_cmd.do_lf || i_cmd.do_wrap) begin
                r_cur_col <= '0;
                r_cur_row <= r_cur_row + 1'b1;
            end
            if (i_cmd.write_cell || (i_cmd.fill_step && r_cnt_col == LAST_COL)) begin
                r_drawn   <= 1'b1;
                r_dcol    <= r_cur_col[4:0];
                r_drow    <= r_cur_row[3:0];
                r_dchar   <= ch_f;
                r_cur_col <= r_cur_col + 1'b1;
            end
            if (i_cmd.fill_step && r_cnt_col == LAST_COL) begin
                r_row_vld[r_cur_row[RW-1:0]] <= 1'b1;
            end
            if (i_cmd.result_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.command     = r_command;
        o_stat.need_scroll = r_cur_row >= rows;
        o_stat.is_cr       = r_ch == stc_pkg::CR_CODE;
        o_stat.is_lf       = r_ch == stc_pkg::LF_CODE;
        o_stat.line_end    = r_cur_col >= cols;
        o_stat.wrap_en     = r_wrap;
        o_stat.wrap_scroll = ({1'b0, r_cur_row} + 1'b1) >= {1'b0, rows};
        o_stat.row_valid   = r_row_vld[r_cur_row[RW-1:0]];
        o_stat.copy_idle   = !(r_cnt_row < rows) && !r_cp_vld;
        o_stat.fill_last   = r_cnt_col == LAST_COL;
        o_stat.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

// File: hdl/scrolling_text_console.sv
// Top level of the scrolling text console.
`timescale 1ns / 1ps
// Commands enter on the s_axis channel: put character, move cursor, clear screen or
// read cell. Every accepted command yields exactly one result transfer on m_axis with
// the drawn cell, the scroll count, the cursor after the command and the read cell.
// Registers are written through the cfg channel, which is always ready; write them
// only while no command is in flight.
// One command is handled at a time. A carriage return, a line feed or a dropped
// character writes no cell. A put that writes a character to a row that already holds
// data writes one cell; a put to a row that is still blank since reset or clear writes
// all MAX_COLS cells of that row, the character and spaces. A put also makes at most
// two scrolls, and each scroll copies rows - 1 rows of the store one cell per cycle.
// The block is ready for the next command once a result enters the output register.
// Reset and clear mark all rows blank at once, so blank rows read as spaces and no
// clearing pass is needed. A finished result waits in an output register; the block
// takes the next command while that result is stalled, and holds the second result
// until the receiver frees the register.
module scrolling_text_console #(
    parameter int MAX_COLS = stc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = stc_pkg::MAX_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // command[1:0], char_code[9:2], target_col[14:10], target_row[18:15], zeros
    input  logic [stc_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // drawn[0], draw_col[5:1], draw_row[9:6], draw_char[17:10], scroll_count[19:18],
    // cursor_col_now[25:20], cursor_row_now[30:26], cell_char[38:31], zero
    output logic [stc_pkg::OUT_W-1:0]  o_m_axis_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [stc_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [stc_pkg::CFG_DW-1:0] i_cfg_data
);
    stc_pkg::t_dp_cmd  cmd;
    stc_pkg::t_dp_stat stat;

    stc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stc_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    assign o_s_axis_tready = cmd.in_ready;
    assign o_cfg_ready     = 1'b1;
endmodule
